// File: rtl/core/swd_te_pkg.sv
// Shared types and constants for the SWD host transfer engine.
`default_nettype none

package swd_te_pkg;

    localparam int unsigned DATA_BITS   = 32;
    localparam int unsigned CNT_W       = 7;
    localparam int unsigned TA_W        = 3;
    localparam int unsigned TA_MAX      = 4;
    localparam int unsigned PADDR_W     = 3;
    localparam int unsigned PDATA_W     = 32;

    // Register byte addresses on the configuration port.
    localparam logic [PADDR_W-1:0] ADDR_TURNAROUND = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_DATA_WAIT  = 3'd4;

    // Raw ACK codes as received, first bit in bit 0.
    localparam logic [2:0] ACK_OK    = 3'b001;
    localparam logic [2:0] ACK_WAIT  = 3'b010;
    localparam logic [2:0] ACK_FAULT = 3'b100;

    // Transfer status codes.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_WAIT   = 3'd1;
    localparam logic [2:0] ST_FAULT  = 3'd2;
    localparam logic [2:0] ST_PROTO  = 3'd3;
    localparam logic [2:0] ST_PARITY = 3'd4;

    // Input item modes.
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_CLOCK = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [7:0]           header;
        logic [DATA_BITS-1:0] write_data;
        logic                 swdio_in;
    } t_in_item;

    typedef struct packed {
        logic                 swdio_out;
        logic                 swdio_drive;
        logic                 busy_res;
        logic                 done_res;
        logic [2:0]           status;
        logic [2:0]           ack_bits;
        logic [DATA_BITS-1:0] read_data;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/core/swd_transfer_engine_top.sv
// SWD host transfer engine: one SWCLK period per clock transaction.
//
// Usage: a start transaction (mode 0) latches the request header and the
// write word when no transfer runs, and is dropped otherwise; it gives no
// result. Each clock transaction (mode 1) stands for one SWCLK period: it
// carries the sampled SWDIO level and gives exactly one result with the
// drive level, output enable, busy and, on the last period, done with the
// status, raw ACK and read word.
// A result is registered in the output register, or in the skid register if
// the output is stalled. One transaction per cycle while the input stall is
// low; the transfer state is updated by a single registered step per period.
// The output side has a main register and a skid register, so an input
// transaction is still taken while a result waits; the input stall rises
// only once the skid register is occupied, and falls as the receiver drains.
// Reset clears the transfer state to idle, empties both output registers
// and sets the turnaround count to 1 and the dummy data phases off.
// Configuration writes go through the APB port with pready tied high.
`default_nettype none

module swd_transfer_engine_top
    import swd_te_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_item           i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_HDR   = 4'd1;
    localparam logic [3:0] PH_TA1   = 4'd2;
    localparam logic [3:0] PH_ACK   = 4'd3;
    localparam logic [3:0] PH_RDATA = 4'd4;
    localparam logic [3:0] PH_RPAR  = 4'd5;
    localparam logic [3:0] PH_TA2   = 4'd6;
    localparam logic [3:0] PH_WTA   = 4'd7;
    localparam logic [3:0] PH_WDATA = 4'd8;
    localparam logic [3:0] PH_WPAR  = 4'd9;
    localparam logic [3:0] PH_DRD   = 4'd10;
    localparam logic [3:0] PH_DTA   = 4'd11;
    localparam logic [3:0] PH_DWR   = 4'd12;
    localparam logic [3:0] PH_BACK  = 4'd13;

    localparam logic [CNT_W-1:0] CNT_HDR  = CNT_W'(8);
    localparam logic [CNT_W-1:0] CNT_ACK  = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_DATA = CNT_W'(DATA_BITS);
    localparam logic [CNT_W-1:0] CNT_DUMMY = CNT_W'(DATA_BITS + 1);

    // Configuration registers.
    logic [TA_W-1:0]      r_ta;
    logic                 r_data_wait;

    // Transfer state.
    logic [3:0]           r_phase,   n_phase;
    logic [CNT_W-1:0]     r_cnt,     n_cnt;
    logic [7:0]           r_hdr,     n_hdr;
    logic [DATA_BITS-1:0] r_data,    n_data;
    logic                 r_is_read, n_is_read;
    logic [2:0]           r_ack,     n_ack;
    logic                 r_par,     n_par;

    // Output main and skid registers.
    logic                 r_out_valid;
    t_out_item            r_out;
    logic                 r_skid_valid;
    t_out_item            r_skid;

    logic                 in_accept;
    logic                 res_valid;
    logic                 out_free;
    t_out_item            res;
    logic                 cfg_write;

    function automatic logic [CNT_W-1:0] ta_len(input logic [TA_W-1:0] t);
        logic [CNT_W-1:0] v;
        begin
            if (t == '0) begin
                v = CNT_W'(1);
            end else if (t > TA_W'(TA_MAX)) begin
                v = CNT_W'(TA_MAX);
            end else begin
                v = CNT_W'(t);
            end
            return v;
        end
    endfunction

    assign in_accept = i_in_valid && !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign res_valid = in_accept && (i_in_data.mode == MODE_CLOCK);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[2] == ADDR_DATA_WAIT[2]) begin
            prdata[0] = r_data_wait;
        end else begin
            prdata[TA_W-1:0] = r_ta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ta        <= TA_W'(1);
            r_data_wait <= 1'b0;
        end else if (cfg_write) begin
            if (paddr[2] == ADDR_DATA_WAIT[2]) begin
                r_data_wait <= pwdata[0];
            end else begin
                r_ta <= pwdata[TA_W-1:0];
            end
        end
    end

    // One SWCLK period of the transfer sequencer.
    always_comb begin
        logic             din;
        logic             last;
        logic [CNT_W-1:0] cnt_dec;
        logic [1:0]       pos;
        logic [2:0]       ack_upd;
        logic             finish;
        begin
            n_phase   = r_phase;
            n_cnt     = r_cnt;
            n_hdr     = r_hdr;
            n_data    = r_data;
            n_is_read = r_is_read;
            n_ack     = r_ack;
            n_par     = r_par;

            res             = '0;
            res.swdio_out   = 1'b1;
            res.swdio_drive = 1'b1;

            din     = i_in_data.swdio_in;
            last    = (r_cnt <= CNT_W'(1));
            cnt_dec = last ? '0 : r_cnt - CNT_W'(1);
            finish  = 1'b0;

            // ACK bit position follows the remaining count: 3, 2, 1 give 0, 1, 2.
            pos     = 2'd3 - r_cnt[1:0];
            ack_upd = r_ack;
            if (pos != 2'd3) begin
                ack_upd[pos] = r_ack[pos] | din;
            end

            if (i_in_data.mode == MODE_START) begin
                if (r_phase == PH_IDLE) begin
                    n_hdr     = i_in_data.header;
                    n_data    = i_in_data.write_data;
                    n_is_read = i_in_data.header[2];
                    n_ack     = '0;
                    n_par     = 1'b0;
                    n_phase   = PH_HDR;
                    n_cnt     = CNT_HDR;
                end
            end else if (r_phase != PH_IDLE) begin
                res.busy_res    = 1'b1;
                res.swdio_out   = 1'b0;
                res.swdio_drive = 1'b0;
                n_cnt           = cnt_dec;
                unique case (r_phase)
                    PH_HDR: begin
                        res.swdio_drive = 1'b1;
                        res.swdio_out   = r_hdr[0];
                        n_hdr           = {1'b0, r_hdr[7:1]};
                        if (last) begin
                            n_phase = PH_TA1;
                            n_cnt   = ta_len(r_ta);
                        end
                    end
                    PH_TA1: begin
                        if (last) begin
                            n_phase = PH_ACK;
                            n_cnt   = CNT_ACK;
                        end
                    end
                    PH_ACK: begin
                        n_ack = ack_upd;
                        if (last) begin
                            if (ack_upd == ACK_OK) begin
                                if (r_is_read) begin
                                    n_data  = '0;
                                    n_par   = 1'b0;
                                    n_phase = PH_RDATA;
                                    n_cnt   = CNT_DATA;
                                end else begin
                                    n_phase = PH_WTA;
                                    n_cnt   = ta_len(r_ta);
                                end
                            end else if (ack_upd == ACK_WAIT || ack_upd == ACK_FAULT) begin
                                if (r_data_wait) begin
                                    n_phase = PH_DRD;
                                    n_cnt   = CNT_DUMMY;
                                end else begin
                                    n_phase = PH_DTA;
                                    n_cnt   = ta_len(r_ta);
                                end
                            end else begin
                                n_phase = PH_BACK;
                                n_cnt   = ta_len(r_ta) + CNT_DUMMY;
                            end
                        end
                    end
                    PH_RDATA: begin
                        n_data = {din, r_data[DATA_BITS-1:1]};
                        n_par  = r_par ^ din;
                        if (last) begin
                            n_phase = PH_RPAR;
                            n_cnt   = CNT_W'(1);
                        end
                    end
                    PH_RPAR: begin
                        n_par   = r_par ^ din;
                        n_phase = PH_TA2;
                        n_cnt   = ta_len(r_ta);
                    end
                    PH_TA2: begin
                        finish = last;
                    end
                    PH_WTA: begin
                        if (last) begin
                            n_par   = 1'b0;
                            n_phase = PH_WDATA;
                            n_cnt   = CNT_DATA;
                        end
                    end
                    PH_WDATA: begin
                        res.swdio_drive = 1'b1;
                        res.swdio_out   = r_data[0];
                        n_par           = r_par ^ r_data[0];
                        n_data          = {1'b0, r_data[DATA_BITS-1:1]};
                        if (last) begin
                            n_phase = PH_WPAR;
                            n_cnt   = CNT_W'(1);
                        end
                    end
                    PH_WPAR: begin
                        res.swdio_drive = 1'b1;
                        res.swdio_out   = r_par;
                        n_cnt           = r_cnt;
                        finish          = 1'b1;
                    end
                    PH_DRD: begin
                        if (last) begin
                            n_phase = PH_DTA;
                            n_cnt   = ta_len(r_ta);
                        end
                    end
                    PH_DTA: begin
                        if (last) begin
                            if (r_data_wait) begin
                                n_phase = PH_DWR;
                                n_cnt   = CNT_DUMMY;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                    end
                    PH_DWR: begin
                        res.swdio_drive = 1'b1;
                        finish          = last;
                    end
                    default: begin
                        // Back-off after a protocol error, and unused codes.
                        finish = last;
                    end
                endcase

                if (finish) begin
                    res.done_res = 1'b1;
                    res.ack_bits = r_ack;
                    if (r_ack == ACK_OK) begin
                        res.status = ST_OK;
                        if (r_is_read) begin
                            res.read_data = r_data;
                            if (r_par) begin
                                res.status = ST_PARITY;
                            end
                        end
                    end else if (r_ack == ACK_WAIT) begin
                        res.status = ST_WAIT;
                    end else if (r_ack == ACK_FAULT) begin
                        res.status = ST_FAULT;
                    end else begin
                        res.status = ST_PROTO;
                    end
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_hdr     <= '0;
            r_data    <= '0;
            r_is_read <= 1'b0;
            r_ack     <= '0;
            r_par     <= 1'b0;
        end else if (in_accept) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_hdr     <= n_hdr;
            r_data    <= n_data;
            r_is_read <= n_is_read;
            r_ack     <= n_ack;
            r_par     <= n_par;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_valid) begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/swd_te_checker.sv
// Port-level checks for the SWD host transfer engine, bound to its top level.
`default_nettype none

module swd_te_checker
    import swd_te_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data,
    input wire logic      pready
);

    // The input side stalls only while a result is waiting in the output stage.
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A released line always reads as low.
    a_released_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.swdio_drive |-> !o_out_data.swdio_out)
        else $error("released line shows a high level");

    // The last period of a transfer is part of the transfer.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> o_out_data.busy_res)
        else $error("done reported outside a transfer");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind swd_transfer_engine_top swd_te_checker u_swd_te_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .pready      (pready)
);

`default_nettype wire
